// ===== rtl/string_escape_decoder_top_assert.svh =====
// Assertion macros used by the checker of the string escape decoder.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

// Checked at every clock edge outside of reset.
`define SED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
// Package of the string escape decoder: status codes, character constants
// and the hex digit decode. Depends on nothing.
`default_nettype none

package sed_pkg;

  localparam int unsigned CharW  = 21;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PendW  = 3;
  localparam int unsigned DigitW = 4;

  typedef enum logic [StatW-1:0] {
    ST_OK           = 3'd0,
    ST_MISSING      = 3'd1,
    ST_UNTERMINATED = 3'd2,
    ST_BAD_HEX      = 3'd3,
    ST_BAD_ESCAPE   = 3'd4,
    ST_SURROGATE    = 3'd5
  } status_e;

  localparam logic [CharW-1:0] CharB      = 21'h62;
  localparam logic [CharW-1:0] CharT      = 21'h74;
  localparam logic [CharW-1:0] CharN      = 21'h6e;
  localparam logic [CharW-1:0] CharF      = 21'h66;
  localparam logic [CharW-1:0] CharR      = 21'h72;
  localparam logic [CharW-1:0] CharU      = 21'h75;
  localparam logic [CharW-1:0] CharQuote  = 21'h22;
  localparam logic [CharW-1:0] CharApos   = 21'h27;
  localparam logic [CharW-1:0] CharBslash = 21'h5c;
  localparam logic [CharW-1:0] CharSlash  = 21'h2f;

  localparam logic [CodeW-1:0] CodeBs = 16'd8;
  localparam logic [CodeW-1:0] CodeHt = 16'd9;
  localparam logic [CodeW-1:0] CodeLf = 16'd10;
  localparam logic [CodeW-1:0] CodeFf = 16'd12;
  localparam logic [CodeW-1:0] CodeCr = 16'd13;

  localparam logic [PendW-1:0] HexDigits = 3'd4;

  // Upper five bits of every surrogate code unit.
  localparam logic [4:0] SurrogateTop = 5'b11011;

  typedef struct packed {
    logic              bad;
    logic [DigitW-1:0] value;
  } digit_t;

  // Decodes one ASCII hex digit, upper or lower case.
  function automatic digit_t hex_value(logic [CharW-1:0] c);
    digit_t d;
    d.bad   = 1'b0;
    d.value = c[DigitW-1:0];
    if (c inside {[21'h30:21'h39]}) begin
      d.value = c[DigitW-1:0];
    end else if ((c inside {[21'h41:21'h46]}) || (c inside {[21'h61:21'h66]})) begin
      d.value = c[DigitW-1:0] + 4'd9;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/string_escape_decoder_top.sv =====
// Top level of the string escape decoder: escape letter decode, hex unit
// gathering and the result register. Depends on sed_pkg.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_ready_o   char_code_i, at_end_i
//   out      result     out_valid_o / out_ready_i code_point_o, status_o
//
// One request is taken per cycle; its result, if any, is shown the next cycle.
// The only stage is the result register, which the escape state also feeds.
// A request is taken whenever the result register is empty or being drained.
// Reset clears the escape state and the result valid flag.
`default_nettype none

module string_escape_decoder_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sed_pkg::CharW-1:0]   char_code_i,
  input  wire logic                        at_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [sed_pkg::CodeW-1:0]   code_point_o,
  output logic      [sed_pkg::StatW-1:0]   status_o
);

  logic [sed_pkg::PendW-1:0] pend_q, pend_d;
  logic [sed_pkg::CodeW-1:0] acc_q, acc_d;
  logic                      out_valid_q;
  logic [sed_pkg::CodeW-1:0] code_q;
  sed_pkg::status_e          status_q;

  logic                      in_accept;
  logic                      emit;
  logic [sed_pkg::CodeW-1:0] emit_code;
  sed_pkg::status_e          emit_status;
  sed_pkg::digit_t           digit;
  logic [sed_pkg::CodeW-1:0] acc_next;
  logic [sed_pkg::PendW-1:0] pend_next;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign digit     = sed_pkg::hex_value(char_code_i);
  assign acc_next  = {acc_q[sed_pkg::CodeW-sed_pkg::DigitW-1:0], digit.value};
  assign pend_next = pend_q - 3'd1;

  always_comb begin
    emit        = 1'b0;
    emit_code   = '0;
    emit_status = sed_pkg::ST_OK;
    pend_d      = pend_q;
    acc_d       = acc_q;
    if (pend_q == '0) begin
      if (at_end_i) begin
        emit        = 1'b1;
        emit_status = sed_pkg::ST_MISSING;
      end else begin
        emit = 1'b1;
        case (char_code_i)
          sed_pkg::CharB: emit_code = sed_pkg::CodeBs;
          sed_pkg::CharT: emit_code = sed_pkg::CodeHt;
          sed_pkg::CharN: emit_code = sed_pkg::CodeLf;
          sed_pkg::CharF: emit_code = sed_pkg::CodeFf;
          sed_pkg::CharR: emit_code = sed_pkg::CodeCr;
          sed_pkg::CharQuote, sed_pkg::CharApos, sed_pkg::CharBslash,
          sed_pkg::CharSlash: begin
            emit_code = char_code_i[sed_pkg::CodeW-1:0];
          end
          sed_pkg::CharU: begin
            emit   = 1'b0;
            pend_d = sed_pkg::HexDigits;
            acc_d  = '0;
          end
          default: emit_status = sed_pkg::ST_BAD_ESCAPE;
        endcase
      end
    end else if (at_end_i) begin
      emit        = 1'b1;
      emit_status = sed_pkg::ST_UNTERMINATED;
    end else if (digit.bad) begin
      emit        = 1'b1;
      emit_status = sed_pkg::ST_BAD_HEX;
    end else if (pend_next != '0) begin
      pend_d = pend_next;
      acc_d  = acc_next;
    end else begin
      emit = 1'b1;
      if (acc_next[sed_pkg::CodeW-1:sed_pkg::CodeW-5] == sed_pkg::SurrogateTop) begin
        emit_status = sed_pkg::ST_SURROGATE;
      end else begin
        emit_code = acc_next;
      end
    end
    if (emit) begin
      pend_d = '0;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        pend_q      <= pend_d;
        acc_q       <= acc_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      code_q   <= emit_code;
      status_q <= emit_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = code_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ===== rtl/sed_checker.sv =====
// Port-level checker of the string escape decoder, bound to the top level.
// Depends on sed_pkg and string_escape_decoder_top_assert.svh.
`default_nettype none

`include "string_escape_decoder_top_assert.svh"

module sed_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      at_end_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [sed_pkg::CodeW-1:0] code_point_o,
  input wire logic [sed_pkg::StatW-1:0] status_o
);

  `SED_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) && $stable(status_o), "Result dropped or changed while stalled.")
  `SED_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "Request refused with an empty result register.")
  `SED_ASSERT(a_end_gives_result, in_valid_i && in_ready_o && at_end_i |=> out_valid_o, "End of input gave no result.")
  `SED_ASSERT(a_error_zero_code, out_valid_o && status_o != sed_pkg::ST_OK |-> code_point_o == '0, "Error result carries a nonzero code point.")
  `SED_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "Result valid after a reset cycle.")

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (.*);

`default_nettype wire
